// ===== rtl/pcsg_pkg.sv =====
// Shared types, codes and saturation helpers for the PCA subspace log-density block.
// No dependencies; the channels, the top level and the divider import this package.
`timescale 1ns / 1ps
`default_nettype none

package pcsg_pkg;

   // Item modes
   localparam logic [1:0] MODE_SAMPLE   = 2'd0;
   localparam logic [1:0] MODE_MEAN     = 2'd1;
   localparam logic [1:0] MODE_BASIS    = 2'd2;
   localparam logic [1:0] MODE_VARIANCE = 2'd3;

   // Register indexes
   localparam logic [2:0] CSR_DIMS     = 3'd0;
   localparam logic [2:0] CSR_PRINC    = 3'd1;
   localparam logic [2:0] CSR_LN_TOTAL = 3'd2;
   localparam logic [2:0] CSR_LN_PRINC = 3'd3;
   localparam logic [2:0] CSR_CVAR     = 3'd4;

   localparam logic [62:0] SAT62 = {1'b1, 62'd0};
   localparam logic signed [64:0] POS62 = {3'b001, 62'd0};
   localparam logic signed [64:0] NEG62 = -POS62;
   localparam logic signed [65:0] MAX47 = {19'd0, {47{1'b1}}};
   localparam logic signed [65:0] MIN47 = {{19{1'b1}}, 47'd0};

   typedef struct packed {
      logic [1:0]         mode;
      logic [7:0]         row_index;
      logic [4:0]         column_index;
      logic signed [31:0] value;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [47:0] log_density;
      logic signed [47:0] mahalanobis_term;
      logic [46:0]        residual_distance;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  index;
      logic [31:0] wdata;
   } csr_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

   // Unsigned add that sticks at 2^62
   function automatic logic [62:0] sat_add(input logic [62:0] a, input logic [63:0] b);
      logic [64:0] sum;
      sum = {2'b00, a} + {1'b0, b};
      if (sum > {2'b00, SAT62}) return SAT62;
      return sum[62:0];
   endfunction

   // Clamp a signed sum to +-2^62
   function automatic logic signed [63:0] clamp62(input logic signed [64:0] x);
      if (x > POS62) return POS62[63:0];
      if (x < NEG62) return NEG62[63:0];
      return x[63:0];
   endfunction

   // Saturate to 48-bit signed
   function automatic logic signed [47:0] sat48(input logic signed [65:0] x);
      if (x > MAX47) return MAX47[47:0];
      if (x < MIN47) return MIN47[47:0];
      return x[47:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/pcsg_channels.sv =====
// Valid/ready channel interfaces: sample/model items, results and register writes.
// Depends on pcsg_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface pcsg_req_if;
   import pcsg_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface pcsg_rsp_if;
   import pcsg_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface pcsg_csr_if;
   import pcsg_pkg::*;
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/pca_subspace_gaussian_log_density.sv =====
// PCA subspace Gaussian log density. Load beats (mean, basis entry, variance) are taken
// one per cycle while the sequencer is idle. A sample element runs through the one shared
// multiplier: the energy square, then one multiply-accumulate per component up to m, the
// effective principal count. The element marked last adds the closing pass: per component,
// the squared projection and its quotient by the variance, then the DFFS quotient, both on
// the one-bit-per-cycle divider. A finished result sits in an output register, so the
// next beat is taken while it waits. Model stores are not cleared by reset.
`timescale 1ns / 1ps
`default_nettype none

module pca_subspace_gaussian_log_density #(
   parameter int MAX_DIMS      = 256,
   parameter int MAX_PRINCIPAL = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pcsg_req_if.sink    req_ch,
   pcsg_rsp_if.source  rsp_ch,
   pcsg_csr_if.sink    csr_ch
);
   import pcsg_pkg::*;

   localparam int RW  = $clog2(MAX_DIMS);
   localparam int CIW = (MAX_PRINCIPAL > 1) ? $clog2(MAX_PRINCIPAL) : 1;
   localparam int CNW = $clog2(MAX_PRINCIPAL + 1);
   localparam int BAW = $clog2(MAX_DIMS * MAX_PRINCIPAL);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DX    = 4'd1;
   localparam logic [3:0] S_ESQ   = 4'd2;
   localparam logic [3:0] S_EACC  = 4'd3;
   localparam logic [3:0] S_PMUL  = 4'd4;
   localparam logic [3:0] S_PACC  = 4'd5;
   localparam logic [3:0] S_END   = 4'd6;
   localparam logic [3:0] F_SQ    = 4'd7;
   localparam logic [3:0] F_DIV   = 4'd8;
   localparam logic [3:0] F_DWAIT = 4'd9;
   localparam logic [3:0] F_DFFS  = 4'd10;
   localparam logic [3:0] F_QWAIT = 4'd11;
   localparam logic [3:0] F_OUT   = 4'd12;

   // Configuration
   logic [8:0]         dims_ff;
   logic [5:0]         princ_ff;
   logic signed [31:0] ln_total_ff;
   logic signed [31:0] ln_princ_ff;
   logic [30:0]        cvar_ff;

   // Sequencer and datapath registers
   logic [3:0]         state_ff, state_in;
   logic [CNW-1:0]     c_ff, c_in;
   logic [RW-1:0]      row_ff;
   logic signed [31:0] val_ff;
   logic               last_ff;
   logic signed [32:0] dx_ff, dx_in;
   logic [62:0]        energy_ff, energy_in;
   logic [8:0]         cnt_ff, cnt_in;
   logic [62:0]        s_ff, s_in;
   logic [62:0]        bsq_ff, bsq_in;
   logic [46:0]        dffs_ff, dffs_in;
   logic signed [65:0] mahal_ff, mahal_in;
   logic signed [65:0] base_ff;
   logic signed [65:0] ld_ff, ld_in;
   logic [MAX_PRINCIPAL-1:0] vld_ff;

   // Memories and their read registers
   logic signed [31:0] mean_mem  [MAX_DIMS];
   logic signed [31:0] basis_mem [MAX_DIMS*MAX_PRINCIPAL];
   logic signed [31:0] var_mem   [MAX_PRINCIPAL];
   logic signed [63:0] proj_mem  [MAX_PRINCIPAL];
   logic signed [31:0] mean_rd_ff;
   logic signed [31:0] basis_rd_ff;
   logic signed [31:0] var_rd_ff;
   logic signed [63:0] proj_rd_ff;

   rsp_type rsp_data_ff;
   logic    rsp_valid_ff;

   logic               req_fire;
   logic               csr_fire;
   logic               load_rsp;
   logic [RW-1:0]      row_w;
   logic [CIW-1:0]     col_w;
   logic               col_ok;
   logic [CIW-1:0]     c_rd;
   logic [9:0]         m_wide;
   logic [9:0]         dims_m2;
   logic [CNW-1:0]     m_eff;
   logic signed [63:0] proj_old;
   logic signed [63:0] proj_new;
   logic signed [63:0] b_val;
   logic [63:0]        b_abs;
   logic [31:0]        b_sat;
   logic [62:0]        dffs_raw;
   logic [62:0]        q_sat;
   logic [30:0]        cvar_nz;
   logic signed [32:0] op_a, op_b;
   logic signed [65:0] prod;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_fire     = csr_ch.valid && csr_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE) && !reset;
   assign csr_ch.ready = !reset;
   assign load_rsp     = (state_ff == F_OUT) && (!rsp_valid_ff || rsp_ch.ready);
   assign c_rd         = c_in[CIW-1:0];

   // Wrap the row index onto the mean store depth
   if (MAX_DIMS >= 256) begin : g_row_direct
      assign row_w = RW'(req_ch.data.row_index);
   end else begin : g_row_wrap
      logic [RW-1:0] wrap_tab [256];
      for (genvar g = 0; g < 256; g++) begin : g_tab
         assign wrap_tab[g] = RW'(g % MAX_DIMS);
      end
      assign row_w = wrap_tab[req_ch.data.row_index];
   end

   assign col_w  = CIW'(req_ch.data.column_index);
   assign col_ok = int'(req_ch.data.column_index) < MAX_PRINCIPAL;

   // Effective component count
   always_comb begin
      m_wide  = {4'd0, princ_ff};
      dims_m2 = {1'b0, dims_ff} - 10'd2;
      if (m_wide > 10'(MAX_PRINCIPAL)) m_wide = 10'(MAX_PRINCIPAL);
      if (dims_ff < 9'd2) m_wide = '0;
      else if (m_wide > dims_m2) m_wide = dims_m2;
      m_eff = CNW'(m_wide);
   end

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff     <= 9'd256;
         princ_ff    <= 6'd1;
         ln_total_ff <= '0;
         ln_princ_ff <= '0;
         cvar_ff     <= 31'd65536;
      end else if (csr_fire) begin
         unique case (csr_ch.data.index)
            CSR_DIMS:     dims_ff     <= csr_ch.data.wdata[8:0];
            CSR_PRINC:    princ_ff    <= csr_ch.data.wdata[5:0];
            CSR_LN_TOTAL: ln_total_ff <= csr_ch.data.wdata;
            CSR_LN_PRINC: ln_princ_ff <= csr_ch.data.wdata;
            CSR_CVAR:     cvar_ff     <= csr_ch.data.wdata[30:0];
            default: ;
         endcase
      end
   end

   // Model stores: load on beats, projection store on each accumulate, read every cycle
   always_ff @(posedge clock) begin
      if (req_fire && req_ch.data.mode == MODE_MEAN) begin
         mean_mem[row_w] <= req_ch.data.value;
      end
      if (req_fire && req_ch.data.mode == MODE_BASIS && col_ok) begin
         basis_mem[BAW'(int'(row_w) * MAX_PRINCIPAL + int'(col_w))] <= req_ch.data.value;
      end
      if (req_fire && req_ch.data.mode == MODE_VARIANCE && col_ok) begin
         var_mem[col_w] <= req_ch.data.value;
      end
      if (state_ff == S_PACC) begin
         proj_mem[c_ff[CIW-1:0]] <= proj_new;
      end
      mean_rd_ff  <= mean_mem[row_w];
      basis_rd_ff <= basis_mem[BAW'(int'(row_ff) * MAX_PRINCIPAL + int'(c_rd))];
      var_rd_ff   <= var_mem[c_rd];
      proj_rd_ff  <= proj_mem[c_rd];
   end

   // Projection sums count as zero until touched in this vector
   always_ff @(posedge clock) begin
      if (reset || load_rsp) begin
         vld_ff <= '0;
      end else if (state_ff == S_PACC) begin
         vld_ff[c_ff[CIW-1:0]] <= 1'b1;
      end
   end

   // Shared multiplier operand select
   always_comb begin
      proj_old = vld_ff[c_ff[CIW-1:0]] ? proj_rd_ff : 64'sd0;
      b_val    = proj_old;
      b_abs    = b_val[63] ? 64'(-b_val) : 64'(b_val);
      b_sat    = (b_abs > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : b_abs[31:0];
      case (state_ff)
         S_PMUL: begin
            op_a = dx_ff;
            op_b = {basis_rd_ff[31], basis_rd_ff};
         end
         F_SQ: begin
            op_a = {1'b0, b_sat};
            op_b = {1'b0, b_sat};
         end
         default: begin
            op_a = dx_ff;
            op_b = dx_ff;
         end
      endcase
   end

   pcsg_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod)
   );

   assign proj_new = clamp62(65'(proj_old) + 65'(prod >>> 30));

   // Divider requests: b^2 / variance, then the DFFS quotient
   always_comb begin
      cvar_nz  = (cvar_ff == '0) ? 31'd1 : cvar_ff;
      dffs_raw = (energy_ff > bsq_ff) ? (energy_ff - bsq_ff) : 63'd0;
      dffs_in  = (dffs_raw > 63'(MAX47)) ? MAX47[46:0] : dffs_raw[46:0];
      div_req.start = (state_ff == F_DIV) || (state_ff == F_DFFS);
      if (state_ff == F_DIV) begin
         div_req.dividend = prod[63:0];
         div_req.divisor  = (var_rd_ff <= 32'sd0) ? 32'd1 : var_rd_ff;
      end else begin
         div_req.dividend = {1'b0, dffs_in, 16'd0};
         div_req.divisor  = {cvar_nz, 1'b0};
      end
   end

   pcsg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign q_sat = (div_rsp.quotient > {1'b0, SAT62}) ? SAT62 : div_rsp.quotient[62:0];

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      c_in      = c_ff;
      dx_in     = dx_ff;
      energy_in = energy_ff;
      cnt_in    = cnt_ff;
      s_in      = s_ff;
      bsq_in    = bsq_ff;
      mahal_in  = mahal_ff;
      ld_in     = ld_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_ch.data.mode == MODE_SAMPLE) begin
               state_in = S_DX;
               c_in     = '0;
            end
         end
         S_DX: begin
            dx_in    = 33'(val_ff) - 33'(mean_rd_ff);
            state_in = S_ESQ;
         end
         S_ESQ: state_in = S_EACC;
         S_EACC: begin
            energy_in = sat_add(energy_ff, {16'd0, prod[63:16]});
            state_in  = (m_eff == '0) ? S_END : S_PMUL;
         end
         S_PMUL: state_in = S_PACC;
         S_PACC: begin
            c_in     = c_ff + 1'b1;
            state_in = (c_ff + 1'b1 == m_eff) ? S_END : S_PMUL;
         end
         S_END: begin
            c_in = '0;
            if (cnt_ff != 9'd511) cnt_in = cnt_ff + 9'd1;
            if (last_ff) begin
               s_in     = '0;
               bsq_in   = '0;
               state_in = (m_eff == '0) ? F_DFFS : F_SQ;
            end else begin
               state_in = S_IDLE;
            end
         end
         F_SQ: state_in = F_DIV;
         F_DIV: begin
            bsq_in   = sat_add(bsq_ff, {16'd0, prod[63:16]});
            state_in = F_DWAIT;
         end
         F_DWAIT: begin
            if (div_rsp.done) begin
               s_in     = sat_add(s_ff, div_rsp.quotient);
               c_in     = c_ff + 1'b1;
               state_in = (c_ff + 1'b1 == m_eff) ? F_DFFS : F_SQ;
            end
         end
         F_DFFS: begin
            mahal_in = 66'(s_ff[62:1]) - 66'(ln_princ_ff);
            state_in = F_QWAIT;
         end
         F_QWAIT: begin
            if (div_rsp.done) begin
               ld_in    = base_ff - 66'(q_sat);
               state_in = F_OUT;
            end
         end
         F_OUT: begin
            if (load_rsp) begin
               energy_in = '0;
               cnt_in    = '0;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         c_ff      <= '0;
         energy_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         c_ff      <= c_in;
         energy_ff <= energy_in;
         cnt_ff    <= cnt_in;
      end
      if (req_fire) begin
         row_ff  <= row_w;
         val_ff  <= req_ch.data.value;
         last_ff <= req_ch.data.last;
      end
      dx_ff    <= dx_in;
      s_ff     <= s_in;
      bsq_ff   <= bsq_in;
      mahal_ff <= mahal_in;
      ld_ff    <= ld_in;
      base_ff  <= 66'(ln_total_ff) - 66'(ln_princ_ff) - mahal_ff;
      if (state_ff == F_DFFS) dffs_ff <= dffs_in;
   end

   // Result register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_rsp) begin
         rsp_data_ff.log_density       <= sat48(ld_ff);
         rsp_data_ff.mahalanobis_term  <= sat48(mahal_ff);
         rsp_data_ff.residual_distance <= dffs_ff;
         rsp_data_ff.status            <= (cnt_ff != dims_ff);
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // Divider finishes only while the sequencer waits on it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == F_DWAIT || state_ff == F_QWAIT))
      else $error("divider done outside a wait state");

   // A result appears only out of the closing state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == F_OUT)
      else $error("result loaded outside closing state");

   // Sums are cleared once a result is loaded
   a_clear: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (energy_ff == '0 && cnt_ff == '0 && vld_ff == '0))
      else $error("sums not cleared after result");

   // Component loop stays inside the effective count
   a_loop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PMUL || state_ff == F_SQ) |-> c_ff < m_eff)
      else $error("component index past effective count");

endmodule

`default_nettype wire

// ===== rtl/pcsg_mul.sv =====
// Shared 33x33 signed multiplier with a registered product.
// Standalone; used by the top level for energy, projection and squaring.
`timescale 1ns / 1ps
`default_nettype none

module pcsg_mul (
   input  wire logic               clock,
   input  wire logic signed [32:0] op_a,
   input  wire logic signed [32:0] op_b,
   output logic signed [65:0]      prod_ff
);

   // Register the product every cycle
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

endmodule

`default_nettype wire

// ===== rtl/pcsg_div.sv =====
// Restoring divider, 64-bit dividend by 32-bit nonzero divisor, one quotient bit a cycle.
// Depends on pcsg_pkg for the request and response structs.
`timescale 1ns / 1ps
`default_nettype none

module pcsg_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pcsg_pkg::div_req_type div_req,
   output pcsg_pkg::div_rsp_type      div_rsp
);
   import pcsg_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [32:0] shifted;
   logic [32:0] diff;
   logic        fits;

   // One restoring step per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[63]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = shifted >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[31:0] : shifted[31:0];
         quo_in = {quo_ff[62:0], fits};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire
